// File: design/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types, constants and helper functions of the spectrum bin
// post-processor: log2 table, leading-one search and small constant dividers.
// ----------------------------------------------------------------------------
package sbp_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 16;
  localparam int MODE_W = 4;
  localparam int LOG2_W = 5;

  // mode bit positions
  localparam int MODE_ABS    = 0;
  localparam int MODE_SMOOTH = 1;
  localparam int MODE_DB     = 2;
  localparam int MODE_FILT   = 3;

  localparam logic [MODE_W-1:0] POST_MODE_RST = 4'd0;
  localparam logic [LOG2_W-1:0] BIN_LOG2_RST  = 5'd10;

  typedef enum logic [0:0] {
    CFG_POST_MODE      = 1'b0,
    CFG_BIN_COUNT_LOG2 = 1'b1
  } sbp_cfg_e;

  // per-item control that travels with the data through the pipeline
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } sbp_tag_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic              last;
  } sbp_res_t;

  // smoothing: 4*prev + cur + 2, biased by 5*2^31 to stay non-negative
  localparam logic signed [35:0] SM_BIAS  = 36'sd10737418242;
  // filter: sum + 3, biased by 6*2^31 to stay non-negative
  localparam logic signed [35:0] FLT_BIAS = 36'sd12884901891;

  // dB mapping constants, Q16
  localparam int LG_W = 22;
  localparam int PF_W = 6;
  localparam logic signed [41:0] DB_SCALE = 42'sd394566;
  localparam logic signed [25:0] DB_MIN   = -26'sd6553600;
  localparam logic signed [25:0] DB_MAX   = -26'sd1966080;
  localparam logic signed [25:0] DB_OFS   = 26'sd6553600;
  localparam logic [22:0]        DB_HALF  = 23'd2293760;

  // reciprocals for exact floor division of values below 2^20
  localparam logic [20:0] DIV5_M = 21'd1677722;
  localparam logic [20:0] DIV3_M = 21'd1398102;

  // log2(1 + k/64) in Q16 by repeated squaring, evaluated at elaboration
  function automatic logic [64*16-1:0] build_log_tbl();
    logic [64*16-1:0] tbl;
    logic [63:0]      x;
    logic [15:0]      r;
    tbl = '0;
    for (int k = 0; k < 64; k++) begin
      x = 64'(64 + k) << 24;
      r = '0;
      for (int b = 15; b >= 0; b--) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x    = x >> 1;
          r[b] = 1'b1;
        end
      end
      tbl[k*16 +: 16] = r;
    end
    return tbl;
  endfunction

  localparam logic [64*16-1:0] LOG_TBL = build_log_tbl();

  // position of the highest set bit, zero for zero
  function automatic logic [4:0] lod32(input logic [31:0] u);
    logic [4:0] p;
    p = '0;
    for (int b = 0; b < 32; b++) begin
      if (u[b]) begin
        p = 5'(b);
      end
    end
    return p;
  endfunction

  function automatic logic [19:0] div5_20(input logic [19:0] y);
    logic [40:0] prod;
    prod = 41'(y) * 41'(DIV5_M);
    return 20'(prod[40:23]);
  endfunction

  function automatic logic [19:0] div3_20(input logic [19:0] y);
    logic [40:0] prod;
    prod = 41'(y) * 41'(DIV3_M);
    return 20'(prod[40:22]);
  endfunction

endpackage

// File: design/spectrum_bin_postprocess.sv
// ----------------------------------------------------------------------------
// spectrum_bin_postprocess
// Post-processing of a frame of transform bins: absolute value, bin-count
// scaling, smoothing, dB mapping to 0..1 and a 5-tap (1,1,2,1,1)/6 filter.
//
// Bins enter on the slave stream, one per cycle when nothing stalls, and
// results leave on the master stream. Each bin goes through six pipeline
// registers (abs/scale and smoothing sum, two halves of the divide by five,
// log2 lookup, dB multiply and clamp, rescale multiply), the filter stage,
// two halves of the divide by six and a two-entry output queue. The block
// sustains one bin per cycle while the master side takes results; the
// only other exception is the frame-end bin with the filter on, which holds
// the filter stage while it sends out up to the last three filtered bins.
// With the filter on, results trail their bins by two positions and the
// first two bins of a frame give no result of their own. A frame ends on
// tlast or on the bin with index 2^bin_count_log2 - 1, whichever comes
// first. Write the registers only while no bin is in flight.
// ----------------------------------------------------------------------------
module spectrum_bin_postprocess import sbp_pkg::*; #(
  parameter int VALUE_FRAC_BITS    = 16,
  parameter int MAX_BIN_COUNT_LOG2 = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,   // bin_value
  input  logic                s_axis_tlast,   // last_bin
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // result_value, result_index
  output logic                m_axis_tlast,   // last_result
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [LOG2_W-1:0]   cfg_data_i
);

  localparam int CNT_W   = MAX_BIN_COUNT_LOG2;
  localparam int LE_W    = $clog2(MAX_BIN_COUNT_LOG2 + 1);
  localparam int A_W     = VALUE_FRAC_BITS + 6;   // rescale numerator >> 17
  localparam int N_W     = VALUE_FRAC_BITS + 24;  // rescale numerator
  localparam int Q_W     = VALUE_FRAC_BITS + 1;   // 0..2^F
  localparam logic [A_W:0] Div35M = (A_W + 1)'(((64'd1 << (A_W + 6)) + 64'd34) / 64'd35);

  // window position of the filter stage: center two back, one back, current
  localparam logic [1:0] WIN_FULL  = 2'd0;
  localparam logic [1:0] WIN_TAIL1 = 2'd1;
  localparam logic [1:0] WIN_TAIL2 = 2'd2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0] post_mode_q;
  logic [LOG2_W-1:0] bin_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_mode_q <= POST_MODE_RST;
      bin_log2_q  <= BIN_LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (sbp_cfg_e'(cfg_idx_i))
        CFG_POST_MODE:      post_mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_BIN_COUNT_LOG2: bin_log2_q  <= cfg_data_i;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: a stage loads when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic [6:1]  vld_q;
  logic [6:1]  ld;
  sbp_tag_t    tag_q [6:1];
  logic        f_done;
  logic        da_ld;
  logic        db_ld;
  logic        ff_rdy;

  always_comb begin
    ld[6] = !vld_q[6] || f_done;
    for (int k = 5; k >= 1; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign s_axis_tready = ld[1];

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Input stage: frame position, abs, bin-count shift, smoothing numerator
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] bin_value;
  logic                     last_bin;
  logic [CNT_W-1:0]         cnt_q;
  logic [CNT_W-1:0]         cnt_last;
  logic [LE_W-1:0]          le;
  logic                     in_last;
  logic signed [DATA_W-1:0] prev_q;
  logic signed [DATA_W-1:0] v_abs;
  logic signed [DATA_W-1:0] v_sc;
  logic signed [35:0]       sm_x;
  sbp_tag_t                 in_tag;

  assign bin_value = signed'(s_axis_tdata);
  assign last_bin  = s_axis_tlast;

  always_comb begin
    if (bin_log2_q > LOG2_W'(MAX_BIN_COUNT_LOG2)) begin
      le = LE_W'(MAX_BIN_COUNT_LOG2);
    end else begin
      le = LE_W'(bin_log2_q);
    end
    cnt_last = {CNT_W{1'b1}} >> (LE_W'(MAX_BIN_COUNT_LOG2) - le);
    in_last  = last_bin || (cnt_q == cnt_last);

    v_abs = bin_value;
    if (post_mode_q[MODE_ABS] && bin_value[DATA_W-1]) begin
      // the most negative value saturates
      if (bin_value == {1'b1, {(DATA_W-1){1'b0}}}) begin
        v_abs = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        v_abs = -bin_value;
      end
    end
    if (post_mode_q[MODE_ABS] && post_mode_q[MODE_DB]) begin
      v_sc = v_abs >>> le;
    end else begin
      v_sc = v_abs;
    end

    sm_x = (36'(prev_q) <<< 2) + 36'(v_sc) + SM_BIAS;

    in_tag.mode = post_mode_q;
    in_tag.idx  = IDX_W'(cnt_q);
    in_tag.last = in_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= '0;
    end else if (in_acc) begin
      // drop frame state at frame end
      cnt_q  <= in_last ? '0 : cnt_q + 1'b1;
      prev_q <= in_last ? '0 : v_sc;
    end
  end

  // --------------------------------------------------------------------------
  // Stage payloads
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] s1_val_q, s2_val_q, s3_val_q, s4_val_q, s5_val_q, s6_val_q;
  logic [34:0]              s1_y_q;
  logic [17:0]              s2_qh_q;
  logic [2:0]               s2_rh_q;
  logic [16:0]              s2_yl_q;
  logic signed [LG_W-1:0]   s4_lg_q;
  logic                     s4_pos_q, s5_pos_q;
  logic [22:0]              s5_t_q;

  // stage 1 -> 2: upper half of the divide by five
  logic [17:0] dv5_yh;
  logic [19:0] dv5_qh;
  logic [17:0] dv5_rem;

  always_comb begin
    dv5_yh  = s1_y_q[34:17];
    dv5_qh  = div5_20(20'(dv5_yh));
    dv5_rem = dv5_yh - 18'(18'(dv5_qh) * 18'd5);
  end

  // stage 2 -> 3: lower half, remove the bias
  logic [19:0]              dv5_ql;
  logic [DATA_W-1:0]        dv5_q;
  logic signed [DATA_W-1:0] s3_val_d;

  always_comb begin
    dv5_ql = div5_20({s2_rh_q, s2_yl_q});
    dv5_q  = {s2_qh_q[14:0], dv5_ql[16:0]};
    if (tag_q[2].mode[MODE_SMOOTH]) begin
      s3_val_d = signed'(dv5_q ^ {1'b1, {(DATA_W-1){1'b0}}});
    end else begin
      s3_val_d = s2_val_q;
    end
  end

  // stage 3 -> 4: leading one and table lookup give log2 in Q16
  logic [4:0]            lg_p;
  logic [5:0]            lg_frac;
  logic [15:0]           lg_entry;
  logic signed [PF_W-1:0] lg_int;
  logic                  s4_pos_d;

  always_comb begin
    lg_p     = lod32(s3_val_q);
    lg_frac  = 6'({s3_val_q, 6'b0} >> lg_p);
    lg_entry = LOG_TBL[{lg_frac, 4'b0} +: 16];
    lg_int   = signed'(PF_W'(lg_p) - PF_W'(VALUE_FRAC_BITS));
    s4_pos_d = !s3_val_q[DATA_W-1] && (s3_val_q != '0);
  end

  // stage 4 -> 5: 20*log10 in Q16, clamp, offset to 0..70 dB
  logic signed [41:0] db_prod;
  logic signed [25:0] db_raw;
  logic signed [25:0] db_cl;
  logic signed [25:0] db_sh;

  always_comb begin
    db_prod = 42'(s4_lg_q) * DB_SCALE;
    db_raw  = db_prod[41:16];
    if (db_raw < DB_MIN) begin
      db_cl = DB_MIN;
    end else if (db_raw > DB_MAX) begin
      db_cl = DB_MAX;
    end else begin
      db_cl = db_raw;
    end
    db_sh = db_cl + DB_OFS;
  end

  // stage 5 -> 6: round(t * 2^F / (70 * 2^16)) by reciprocal of 35
  logic [N_W-1:0]           rs_num;
  logic [A_W-1:0]           rs_a;
  logic [2*A_W:0]           rs_prod;
  logic [Q_W-1:0]           rs_q;
  logic signed [DATA_W-1:0] s6_val_d;

  always_comb begin
    rs_num  = (N_W'(s5_t_q) << VALUE_FRAC_BITS) + N_W'(DB_HALF);
    rs_a    = rs_num[17 +: A_W];
    rs_prod = (2*A_W + 1)'(rs_a) * (2*A_W + 1)'(Div35M);
    rs_q    = rs_prod[A_W + 6 +: Q_W];
    if (!tag_q[5].mode[MODE_DB]) begin
      s6_val_d = s5_val_q;
    end else if (s5_pos_q) begin
      s6_val_d = signed'(DATA_W'(rs_q));
    end else begin
      s6_val_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[1]) begin
        vld_q[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tag_q[1] <= in_tag;
      s1_val_q <= v_sc;
      s1_y_q   <= sm_x[34:0];
    end
    for (int k = 2; k <= 6; k++) begin
      if (ld[k]) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
    if (ld[2]) begin
      s2_val_q <= s1_val_q;
      s2_qh_q  <= dv5_qh[17:0];
      s2_rh_q  <= dv5_rem[2:0];
      s2_yl_q  <= s1_y_q[16:0];
    end
    if (ld[3]) begin
      s3_val_q <= s3_val_d;
    end
    if (ld[4]) begin
      s4_val_q <= s3_val_q;
      s4_lg_q  <= {lg_int, lg_entry};
      s4_pos_q <= s4_pos_d;
    end
    if (ld[5]) begin
      s5_val_q <= s4_val_q;
      s5_t_q   <= db_sh[22:0];
      s5_pos_q <= s4_pos_q;
    end
    if (ld[6]) begin
      s6_val_q <= s6_val_d;
    end
  end

  // --------------------------------------------------------------------------
  // Filter stage: tap history and emission of up to three results per bin
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] hist_q [4];
  logic [1:0]               sub_q;
  sbp_tag_t                 f_tag;
  logic                     f_filt;
  logic                     f_ge2;
  logic                     f_need;
  logic                     f_emit;
  logic                     f_final;
  logic [1:0]               f_start;
  logic [1:0]               f_cur;
  logic [1:0]               f_fin;
  logic signed [35:0]       f_e [5];
  logic signed [35:0]       f_y;
  logic [IDX_W-1:0]         f_idx;
  logic                     f_last;

  always_comb begin
    f_tag  = tag_q[6];
    f_filt = f_tag.mode[MODE_FILT];
    f_ge2  = |f_tag.idx[IDX_W-1:1];
    f_need = vld_q[6] && (!f_filt || f_tag.last || f_ge2);

    // a short frame starts its tail further right
    if (f_filt && f_tag.last && !f_ge2) begin
      f_start = f_tag.idx[0] ? WIN_TAIL1 : WIN_TAIL2;
    end else begin
      f_start = WIN_FULL;
    end
    f_cur   = f_start + sub_q;
    f_fin   = f_tag.last ? WIN_TAIL2 : WIN_FULL;
    f_final = !f_filt || (f_cur == f_fin);
    f_emit  = f_need && da_ld;
    f_done  = vld_q[6] && (!f_need || (f_emit && f_final));

    unique case (f_cur)
      WIN_FULL: begin
        f_e[0] = 36'(hist_q[3]);
        f_e[1] = 36'(hist_q[2]);
        f_e[2] = 36'(hist_q[1]);
        f_e[3] = 36'(hist_q[0]);
        f_e[4] = 36'(s6_val_q);
      end
      WIN_TAIL1: begin
        f_e[0] = 36'(hist_q[2]);
        f_e[1] = 36'(hist_q[1]);
        f_e[2] = 36'(hist_q[0]);
        f_e[3] = 36'(s6_val_q);
        f_e[4] = '0;
      end
      default: begin
        f_e[0] = 36'(hist_q[1]);
        f_e[1] = 36'(hist_q[0]);
        f_e[2] = 36'(s6_val_q);
        f_e[3] = '0;
        f_e[4] = '0;
      end
    endcase
    f_y = f_e[0] + f_e[1] + (f_e[2] <<< 1) + f_e[3] + f_e[4] + FLT_BIAS;

    if (f_filt) begin
      f_idx  = f_tag.idx + IDX_W'(f_cur) - IDX_W'(2);
      f_last = f_tag.last && (f_cur == WIN_TAIL2);
    end else begin
      f_idx  = f_tag.idx;
      f_last = f_tag.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
      for (int k = 0; k < 4; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (f_done) begin
        sub_q <= '0;
      end else if (f_emit) begin
        sub_q <= sub_q + 1'b1;
      end
      // history advances in every mode; clear it at frame end
      if (f_done) begin
        if (f_tag.last) begin
          for (int k = 0; k < 4; k++) begin
            hist_q[k] <= '0;
          end
        end else begin
          hist_q[3] <= hist_q[2];
          hist_q[2] <= hist_q[1];
          hist_q[1] <= hist_q[0];
          hist_q[0] <= s6_val_q;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divide by six: halve, then two halves of a divide by three
  // --------------------------------------------------------------------------
  logic                     da_v_q, db_v_q;
  logic [33:0]              da_y_q;
  logic signed [DATA_W-1:0] da_val_q, db_val_q;
  logic                     da_byp_q, db_byp_q;
  logic [IDX_W-1:0]         da_idx_q, db_idx_q;
  logic                     da_last_q, db_last_q;
  logic [16:0]              db_qh_q;
  logic [1:0]               db_rh_q;
  logic [16:0]              db_yl_q;

  assign db_ld = !db_v_q || ff_rdy;
  assign da_ld = !da_v_q || db_ld;

  logic [16:0]       dv3_yh;
  logic [19:0]       dv3_qh;
  logic [16:0]       dv3_rem;
  logic [19:0]       dv3_ql;
  logic [DATA_W-1:0] dv3_q;
  sbp_res_t          res_d;

  always_comb begin
    dv3_yh  = da_y_q[33:17];
    dv3_qh  = div3_20(20'(dv3_yh));
    dv3_rem = dv3_yh - 17'(17'(dv3_qh) * 17'd3);

    dv3_ql  = div3_20(20'({db_rh_q, db_yl_q}));
    dv3_q   = {db_qh_q[14:0], dv3_ql[16:0]};

    res_d.idx  = db_idx_q;
    res_d.last = db_last_q;
    if (db_byp_q) begin
      res_d.value = db_val_q;
    end else begin
      res_d.value = dv3_q ^ {1'b1, {(DATA_W-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      da_v_q <= 1'b0;
      db_v_q <= 1'b0;
    end else begin
      if (da_ld) begin
        da_v_q <= f_emit;
      end
      if (db_ld) begin
        db_v_q <= da_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_emit) begin
      da_y_q    <= f_y[34:1];
      da_val_q  <= s6_val_q;
      da_byp_q  <= !f_filt;
      da_idx_q  <= f_idx;
      da_last_q <= f_last;
    end
    if (db_ld && da_v_q) begin
      db_qh_q   <= dv3_qh[16:0];
      db_rh_q   <= dv3_rem[1:0];
      db_yl_q   <= da_y_q[16:0];
      db_val_q  <= da_val_q;
      db_byp_q  <= da_byp_q;
      db_idx_q  <= da_idx_q;
      db_last_q <= da_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue: two entries keep the master side off the pipeline ready path
  // --------------------------------------------------------------------------
  sbp_res_t    ff_mem_q [2];
  logic        ff_wptr_q, ff_rptr_q;
  logic [1:0]  ff_cnt_q;
  logic        ff_push, ff_pop;
  sbp_res_t    ff_head;

  assign ff_rdy  = (ff_cnt_q != 2'd2);
  assign ff_push = db_v_q && ff_rdy;
  assign ff_pop  = m_axis_tvalid && m_axis_tready;
  assign ff_head = ff_mem_q[ff_rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_wptr_q <= 1'b0;
      ff_rptr_q <= 1'b0;
      ff_cnt_q  <= '0;
    end else begin
      if (ff_push) begin
        ff_wptr_q <= !ff_wptr_q;
      end
      if (ff_pop) begin
        ff_rptr_q <= !ff_rptr_q;
      end
      ff_cnt_q <= ff_cnt_q + {1'b0, ff_push} - {1'b0, ff_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ff_push) begin
      ff_mem_q[ff_wptr_q] <= res_d;
    end
  end

  logic signed [DATA_W-1:0] result_value;
  logic [IDX_W-1:0]         result_index;
  logic                     last_result;

  assign result_value  = signed'(ff_head.value);
  assign result_index  = ff_head.idx;
  assign last_result   = ff_head.last;

  assign m_axis_tvalid = (ff_cnt_q != 2'd0);
  assign m_axis_tdata  = {result_index, result_value};
  assign m_axis_tlast  = last_result;

endmodule

// File: verif/spectrum_bin_postprocess_tb.sv
// ----------------------------------------------------------------------------
// spectrum_bin_postprocess_tb
// Self-checking bench for the spectrum bin post-processor. A bit-exact
// predictor of the abs, scale, smoothing, dB and 5-tap filter chain turns
// every accepted bin into the results it should cause. Each result transfer
// on the master stream is checked field by field against the oldest of
// those. A short table of directed bins comes first, then random frames run
// under four idling patterns on both streams.
// ----------------------------------------------------------------------------
module spectrum_bin_postprocess_tb;
  import sbp_pkg::*;

  localparam int     ITEMS_PER_PHASE = 83;
  localparam int     SETTLE_CYCLES   = 16;    // pipeline depth plus the frame-end flush
  localparam int     WATCHDOG_LIMIT  = 2000;
  localparam int     PRINT_CAP       = 40;
  localparam int     N_DIRECTED      = 37;
  localparam int     VALUE_FRAC      = 16;
  localparam int     MAX_LOG2        = 16;
  localparam longint Q16_ONE         = 65536;
  localparam longint DB_SCALE_Q16    = 394566;
  localparam longint DB_FLOOR        = -100 * Q16_ONE;
  localparam longint DB_CEIL         = -30 * Q16_ONE;

  // mode values as written to the post_mode register
  localparam logic [LOG2_W-1:0] M_OFF    = '0;
  localparam logic [LOG2_W-1:0] M_ABS    = LOG2_W'(1 << MODE_ABS);
  localparam logic [LOG2_W-1:0] M_SMOOTH = LOG2_W'(1 << MODE_SMOOTH);
  localparam logic [LOG2_W-1:0] M_DB     = LOG2_W'(1 << MODE_DB);
  localparam logic [LOG2_W-1:0] M_FILT   = LOG2_W'(1 << MODE_FILT);

  typedef enum logic {ROW_REG, ROW_BIN} row_kind_e;

  // one directed step: either a register write or a bin; a pinned bin
  // carries the result value that can be read straight off the spec
  typedef struct packed {
    row_kind_e         kind;
    sbp_cfg_e          reg_idx;
    logic [LOG2_W-1:0] reg_val;
    logic [DATA_W-1:0] bin;
    logic              lst;
    logic              pinned;
    logic [DATA_W-1:0] pinned_value;
  } stim_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_we_i      = 1'b0;
  logic [0:0]        cfg_idx_i     = CFG_POST_MODE;
  logic [LOG2_W-1:0] cfg_data_i    = '0;

  // pinned expectation that travels with the bin being driven
  logic              pin_en        = 1'b0;
  logic [DATA_W-1:0] pin_value     = '0;

  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                error_count    = 0;
  int                quiet_cycles   = 0;

  // predictor state, mirrors the block after reset
  logic [MODE_W-1:0] mode_q        = POST_MODE_RST;
  logic [LOG2_W-1:0] bin_log2_q    = BIN_LOG2_RST;
  longint            prev_scaled_q = 0;
  longint            taps_q [4]    = '{default: 0};
  logic [IDX_W-1:0]  bin_idx_q     = '0;
  sbp_res_t          expected_results [$];

  stim_row_t directed_rows [N_DIRECTED] = '{
    // pass-through after reset: extremes come out untouched
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    // abs: most negative saturates
    '{ROW_REG, CFG_POST_MODE, M_ABS, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h8000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'hFFFF_FFFB, 1'b1, 1'b1, 32'd5},
    // dB alone: non-positive gives zero, huge clamps to full scale
    '{ROW_REG, CFG_POST_MODE, M_DB, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'hFFFF_0000, 1'b0, 1'b1, 32'd0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0000_0000, 1'b0, 1'b1, 32'd0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'd65536},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
    // two-bin frames, everything on, frame ends on the count
    '{ROW_REG, CFG_BIN_COUNT_LOG2, 5'd1, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, CFG_POST_MODE, M_ABS | M_SMOOTH | M_DB | M_FILT, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
    // bin count zero: every bin is a frame of its own
    '{ROW_REG, CFG_BIN_COUNT_LOG2, 5'd0, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0040_0000, 1'b0, 1'b0, 32'h0},
    // bin count above the maximum acts as the maximum
    '{ROW_REG, CFG_BIN_COUNT_LOG2, 5'd31, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, CFG_POST_MODE, M_SMOOTH | M_FILT, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'hFFFE_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0000_0003, 1'b1, 1'b0, 32'h0},
    // filter on one-bin and two-bin frames
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0000_1000, 1'b1, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0002_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0003_0000, 1'b1, 1'b0, 32'h0},
    // filter switched off in the middle of a frame
    '{ROW_REG, CFG_POST_MODE, M_FILT, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0005_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0006_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h0007_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, CFG_POST_MODE, M_ABS, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'hFFF0_0000, 1'b1, 1'b0, 32'h0},
    // largest bin count, abs plus dB shifts by sixteen
    '{ROW_REG, CFG_BIN_COUNT_LOG2, 5'd16, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_REG, CFG_POST_MODE, M_ABS | M_DB, 32'h0, 1'b0, 1'b0, 32'h0},
    '{ROW_BIN, CFG_POST_MODE, M_OFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0}
  };

  spectrum_bin_postprocess dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),    // bin_value
    .s_axis_tlast (s_axis_tlast),    // last_bin
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),    // result_value [31:0], result_index [47:32]
    .m_axis_tlast (m_axis_tlast),    // last_result
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: decide the stall for the next edge on every falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // log2(1 + k/64) in Q16: square a Q30 mantissa sixteen times, truncating,
  // and pick up one result bit each time it crosses two
  function automatic longint log2_mantissa(int unsigned k);
    longint unsigned x;
    longint          r;
    x = 64'(64 + k) << 24;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r = r | (longint'(1) << b);
      end
    end
    return r;
  endfunction

  // 20*log10 in Q16, clamped to -100..-30 dB, then rescaled to 0..1
  function automatic longint db_level(longint v);
    logic [31:0] u;
    int          p;
    int unsigned k;
    longint      lg;
    longint      db;
    longint      t;
    if (v <= 0) return 0;
    u = v[31:0];
    p = 31;
    while (p > 0 && !u[p]) p--;
    if (p < 6) k = (u << (6 - p)) & 32'd63;
    else k = (u >> (p - 6)) & 32'd63;
    lg = longint'(p - VALUE_FRAC) * Q16_ONE + log2_mantissa(k);
    db = floor_quot(lg * DB_SCALE_Q16, Q16_ONE);
    if (db < DB_FLOOR) db = DB_FLOOR;
    if (db > DB_CEIL) db = DB_CEIL;
    t = db - DB_FLOOR;
    return (t * (longint'(1) << VALUE_FRAC) + 35 * Q16_ONE) / (70 * Q16_ONE);
  endfunction

  // Advance the predictor by one accepted bin and queue the results it causes.
  task automatic predict_bin(input logic [DATA_W-1:0] raw, input logic lst);
    longint      v;
    longint      s;
    longint      sum;
    longint      w [7];
    int unsigned le;
    int unsigned i;
    int unsigned j;
    int unsigned first;
    int unsigned c;
    bit          frame_end;
    sbp_res_t    r;
    v  = $signed(raw);
    le = (bin_log2_q > MAX_LOG2) ? MAX_LOG2 : bin_log2_q;
    i  = bin_idx_q;
    if (mode_q[MODE_ABS]) begin
      if (v < 0) v = -v;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
    // scale by the bin count only when abs and dB are both on
    if (mode_q[MODE_ABS] && mode_q[MODE_DB]) v = v >>> le;
    s = v;
    if (mode_q[MODE_SMOOTH]) v = floor_quot(4 * prev_scaled_q + v + 2, 5);
    prev_scaled_q = s;
    if (mode_q[MODE_DB]) v = db_level(v);
    frame_end = lst || (i == (32'd1 << le) - 1);

    if (mode_q[MODE_FILT]) begin
      // window: four older bins, the current one, zero padding past the end
      w[0] = taps_q[3];
      w[1] = taps_q[2];
      w[2] = taps_q[1];
      w[3] = taps_q[0];
      w[4] = v;
      w[5] = 0;
      w[6] = 0;
      first = (i >= 2) ? i - 2 : (frame_end ? 0 : 1);
      if (frame_end || i >= 2) begin
        for (j = first; j <= i; j++) begin
          c       = j + 4 - i;
          sum     = w[c-2] + w[c-1] + 2 * w[c] + w[c+1] + w[c+2];
          r.value = DATA_W'(floor_quot(sum + 3, 6));
          r.idx   = IDX_W'(j);
          r.last  = frame_end && (j == i);
          expected_results.push_back(r);
          if (!frame_end) break;
        end
      end
    end else begin
      r.value = DATA_W'(v);
      r.idx   = IDX_W'(i);
      r.last  = frame_end;
      expected_results.push_back(r);
    end

    taps_q[3] = taps_q[2];
    taps_q[2] = taps_q[1];
    taps_q[1] = taps_q[0];
    taps_q[0] = v;
    if (frame_end) begin
      bin_idx_q     = '0;
      prev_scaled_q = 0;
      taps_q        = '{default: 0};
    end else begin
      bin_idx_q = IDX_W'(i + 1);
    end
  endtask

  task automatic flag_mismatch(input string field, input longint exp_v, input longint got_v);
    if (error_count < PRINT_CAP) begin
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
    end
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both streams on the rising edge, before the block updates.
  // Check results first, then feed the accepted bin to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sbp_res_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          if (error_count < PRINT_CAP) begin
            $error("unexpected result: value %0d index %0d last %0b",
                   $signed(m_axis_tdata[31:0]), m_axis_tdata[47:32], m_axis_tlast);
          end
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.value) begin
            flag_mismatch("result_value", $signed(exp_r.value), $signed(m_axis_tdata[31:0]));
          end
          if (m_axis_tdata[47:32] !== exp_r.idx) begin
            flag_mismatch("result_index", exp_r.idx, m_axis_tdata[47:32]);
          end
          if (m_axis_tlast !== exp_r.last) begin
            flag_mismatch("last_result", exp_r.last, m_axis_tlast);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        predict_bin(s_axis_tdata, s_axis_tlast);
        // pinned rows override the computed value with the hand-read one
        if (pin_en) expected_results[expected_results.size()-1].value = pin_value;
      end

      // Watchdog: count edges that move nothing; give up when it gets too long.
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks: called on a falling edge, return on a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one bin, with random idle cycles in front; hold it until the transfer.
  task automatic send_bin(input logic [DATA_W-1:0] v, input logic lst,
                          input logic pinned, input logic [DATA_W-1:0] pinned_value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= lst;
    pin_en        <= pinned;
    pin_value     <= pinned_value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid, drain every expected result, then let bins that cause no
  // result clear the pipeline.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register while the block is idle and mirror it in the predictor.
  task automatic write_reg(input sbp_cfg_e idx, input logic [LOG2_W-1:0] val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_POST_MODE) mode_q = val[MODE_W-1:0];
    else bin_log2_q = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int                send_pcts [4] = '{0, 51, 0, 15};
    int                recv_pcts [4] = '{0, 0, 51, 15};
    int                sent;
    int unsigned       len;
    int unsigned       pick;
    logic [DATA_W-1:0] val;
    logic              lst;

    // hold reset low, then release it on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, no idling
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_REG) begin
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        send_bin(directed_rows[r].bin, directed_rows[r].lst,
                 directed_rows[r].pinned, directed_rows[r].pinned_value);
      end
    end

    // random frames under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      sent           = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // retune between frames, sometimes with a frame still open
        if ($urandom_range(99) < 40) begin
          write_reg(CFG_POST_MODE, LOG2_W'($urandom_range(15)));
        end
        if ($urandom_range(99) < 25) begin
          pick = $urandom_range(19);
          if (pick < 14) val = $urandom_range(1, 5);
          else if (pick < 17) val = 16;
          else val = $urandom_range(31);
          write_reg(CFG_BIN_COUNT_LOG2, LOG2_W'(val));
        end
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(3))
            0: val = $urandom;
            1: begin
              // spread over all magnitudes so every log table entry shows up
              val = $urandom >> $urandom_range(31);
              if ($urandom_range(1)) val = -val;
            end
            2: begin
              pick = $urandom_range(4);
              if (pick == 0) val = 32'h7FFF_FFFF;
              else if (pick == 1) val = 32'h8000_0000;
              else if (pick == 2) val = 32'h0000_0000;
              else if (pick == 3) val = 32'h0000_0001;
              else val = 32'hFFFF_FFFF;
            end
            default: begin
              val = $urandom_range(100 << 16);
              if ($urandom_range(1)) val = -val;
            end
          endcase
          // leave a frame open now and then so the next one continues it
          lst = (k == len - 1) && ($urandom_range(9) != 0);
          send_bin(val, lst, 1'b0, '0);
          sent++;
        end
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
